### rtl/core/stq_pkg.sv
// Package: status codes and request codes for the sorted timer queue.
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;
    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_MODIFY = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_TICK   = 2'd3
    } t_req;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_EXPIRED   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_PRESENT   = 3'd4;

    localparam int ID_BITS     = 4;
    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic [2:0]         status;
        logic [ID_BITS-1:0] expired_id;
        logic               last;
    } t_result;
endpackage
`default_nettype wire

### rtl/core/stq_out_reg.sv
// Output skid register: one result slot holding status, id and last.
`timescale 1ns / 1ps
`default_nettype none
module stq_out_reg
    import stq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_res,
    output logic         o_ready,
    output logic         o_valid,
    output t_result      o_res,
    input  wire logic    i_ready
);
    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end
endmodule
`default_nettype wire

### rtl/core/sorted_timer_queue.sv
// Top level: sorted timer table kept in one synchronous memory.
//
// Slave channel takes requests (add, modify, delete, tick); master channel
// returns results. Add, modify and delete give one status result. A tick
// gives one result per expired timer, up to MAX_RESULTS, front first, with
// tlast on the final one, or one "done" result if nothing expired.
// The table lives in a one-port-read memory of MAX_TIMERS entries, each one
// {id, expiry}. A request scans the table one entry per cycle, with the read
// data registered: find looks for the id, then removal shifts later entries
// down, or insert scans for the place and shifts later entries up. A tick
// pops entries from slot 0 with one shift pass per popped entry.
// Reset clears the entry count; memory contents need no clearing.
// A stalled receiver holds the sequencer at the result step; one result
// sits in the output register, so the next step proceeds while it waits.
`timescale 1ns / 1ps
`default_nettype none
module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int MAX_TIMERS = 16,
    parameter int TIME_BITS  = 32
)(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: req_type[1:0], timer_id[5:2], expire_time[37:6], now_time[69:38]
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: status[2:0], expired_id[6:3]
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast
);
    localparam int IW = $clog2(MAX_TIMERS);
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam int EW = ID_BITS + TIME_BITS;
    localparam int RW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_DEC, S_RMV, S_INS_SCAN, S_INS_SHIFT,
        S_INS_WRITE, S_TICK_RD, S_TICK_CHK, S_EMIT
    } t_state;

    logic [EW-1:0] r_mem [MAX_TIMERS];
    logic [EW-1:0] r_rdata;
    logic [IW-1:0] n_raddr;
    logic          n_we;
    logic [IW-1:0] n_waddr;
    logic [EW-1:0] n_wdata;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_pos;
    logic                  r_pend;
    t_req                  r_req;
    logic [ID_BITS-1:0]    r_id;
    logic [TIME_BITS-1:0]  r_exp;
    logic [TIME_BITS-1:0]  r_now;
    logic [RW-1:0]         r_npop;
    t_result               r_res;

    logic    ov_ready;
    t_result ov_res;
    logic    n_push;

    logic [ID_BITS-1:0]   rd_id;
    logic [TIME_BITS-1:0] rd_exp;
    assign rd_id  = r_rdata[EW-1:TIME_BITS];
    assign rd_exp = r_rdata[TIME_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        r_rdata <= r_mem[n_raddr];
    end

    assign s_axis_tready = (r_state == S_IDLE);

    // Memory port control follows the state and index.
    always_comb begin
        n_raddr = r_idx[IW-1:0];
        n_we    = 1'b0;
        n_waddr = r_idx[IW-1:0];
        n_wdata = r_rdata;
        case (r_state)
            S_RMV: begin
                n_raddr = r_idx[IW-1:0];
                n_waddr = IW'(r_idx - CW'(2));
                n_we    = r_pend;
            end
            S_INS_SHIFT: begin
                n_raddr = IW'(r_idx - CW'(2));
                n_waddr = r_idx[IW-1:0];
                n_we    = r_pend;
            end
            S_INS_WRITE: begin
                n_we    = 1'b1;
                n_wdata = {r_id, r_exp};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_idx   <= '0;
            r_npop  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_req  <= t_req'(s_axis_tdata[1:0]);
                        r_id   <= s_axis_tdata[5:2];
                        r_exp  <= TIME_BITS'(s_axis_tdata[37:6]);
                        r_now  <= TIME_BITS'(s_axis_tdata[69:38]);
                        r_idx  <= '0;
                        r_pend <= 1'b0;
                        r_npop <= '0;
                        if (t_req'(s_axis_tdata[1:0]) == REQ_TICK) begin
                            r_state <= S_TICK_RD;
                        end else begin
                            r_state <= S_FIND;
                        end
                    end
                end
                S_FIND: begin
                    // r_pend: read of slot r_idx-1 is in r_rdata
                    if (r_pend && rd_id == r_id) begin
                        r_pend <= 1'b0;
                        if (r_req == REQ_ADD) begin
                            r_res   <= '{ST_PRESENT, '0, 1'b1};
                            r_state <= S_EMIT;
                        end else begin
                            r_idx   <= r_idx;
                            r_state <= S_DEC;
                        end
                    end else if (r_idx < r_count) begin
                        r_idx  <= r_idx + CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (r_req != REQ_ADD) begin
                            r_res   <= '{ST_NOT_FOUND, '0, 1'b1};
                            r_state <= S_EMIT;
                        end else if (r_count == CW'(MAX_TIMERS)) begin
                            r_res   <= '{ST_FULL, '0, 1'b1};
                            r_state <= S_EMIT;
                        end else begin
                            r_idx   <= '0;
                            r_state <= S_INS_SCAN;
                        end
                    end
                end
                S_DEC: begin
                    // found slot is r_idx-1; shift from r_idx down
                    r_pend  <= 1'b0;
                    r_state <= S_RMV;
                end
                S_RMV: begin
                    // write at r_idx-2 the data read from r_idx-1
                    if (r_idx < r_count) begin
                        r_idx  <= r_idx + CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        r_count <= r_count - CW'(1);
                        if (r_req == REQ_MODIFY) begin
                            r_idx   <= '0;
                            r_state <= S_INS_SCAN;
                        end else if (r_req == REQ_TICK) begin
                            // held for the next check, which sets tlast if no more expire
                            r_npop  <= r_npop + RW'(1);
                            r_res   <= '{ST_EXPIRED, r_id, 1'b0};
                            r_idx   <= '0;
                            r_state <= S_TICK_CHK;
                        end else begin
                            r_res   <= '{ST_DONE, '0, 1'b1};
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_INS_SCAN: begin
                    if (r_pend && rd_exp > r_exp) begin
                        r_pend  <= 1'b0;
                        r_idx   <= r_count + CW'(1);
                        r_pos   <= r_idx - CW'(1);
                        r_state <= S_INS_SHIFT;
                    end else if (r_idx < r_count) begin
                        r_idx  <= r_idx + CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_idx   <= r_count;
                        r_state <= S_INS_WRITE;
                    end
                end
                S_INS_SHIFT: begin
                    // move [pos..cnt-1] up one slot
                    // write at r_idx the data read from r_idx-1
                    if (r_idx > r_pos + CW'(1)) begin
                        r_idx  <= r_idx - CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_idx   <= r_pos;
                        r_state <= S_INS_WRITE;
                    end
                end
                S_INS_WRITE: begin
                    r_count <= r_count + CW'(1);
                    r_npop  <= '0;
                    r_res   <= '{ST_DONE, '0, 1'b1};
                    r_state <= S_EMIT;
                end
                S_TICK_RD: begin
                    r_idx   <= '0;
                    r_state <= S_TICK_CHK;
                    r_pend  <= 1'b0;
                end
                S_TICK_CHK: begin
                    if (!r_pend) begin
                        r_pend <= 1'b1;
                    end else if (r_count != '0 && rd_exp <= r_now
                                 && r_npop < RW'(MAX_RESULTS)) begin
                        r_id   <= rd_id;
                        r_idx  <= CW'(1);
                        r_pend <= 1'b0;
                        if (r_npop != '0) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_DEC;
                        end
                    end else begin
                        r_pend <= 1'b0;
                        if (r_npop == '0) begin
                            r_res <= '{ST_DONE, '0, 1'b1};
                        end else begin
                            r_res.last <= 1'b1;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (ov_ready) begin
                        r_pend <= 1'b0;
                        if (r_req == REQ_TICK && !r_res.last) begin
                            r_state <= S_DEC;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign n_push = (r_state == S_EMIT);

    stq_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n_push),
        .i_res   (r_res),
        .o_ready (ov_ready),
        .o_valid (m_axis_tvalid),
        .o_res   (ov_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, ov_res.expired_id, ov_res.status};
    assign m_axis_tlast = ov_res.last;
endmodule
`default_nettype wire

### rtl/core/stq_checker.sv
// Port checker for the sorted timer queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module stq_checker
    import stq_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_PRESENT)
        else $error("bad status");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_EXPIRED |-> m_axis_tlast)
        else $error("status result without tlast");
endmodule
bind sorted_timer_queue stq_checker u_stq_checker (.*);
`default_nettype wire
